### design/nrlt_pkg.sv
`default_nettype none

package nrlt_pkg;

    // default geometry
    localparam int BUCKET_BITS_DEF = 8;
    localparam int WAYS_DEF        = 4;

    // stored key: valid, addr wildcard, addr, port wildcard, port
    localparam int KEY_W        = 51;
    localparam int KEY_VALID_B  = 50;
    localparam int KEY_IPANY_B  = 49;
    localparam int KEY_IP_LSB   = 17;
    localparam int KEY_PANY_B   = 16;

    // stored target: translated addr (47:16), translated port (15:0)
    localparam int TGT_W  = 48;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;

    // bucket hash input: low address octet over low port octet
    localparam int OCTET_W   = 8;
    localparam int HASH_IN_W = 2 * OCTET_W;

    // beat layouts
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 48;

    // item kind carried in tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_EXACT   = 3'd2,
        ST_IPANY   = 3'd3,
        ST_PORTANY = 3'd4,
        ST_MISS    = 3'd5
    } t_status;

endpackage

`default_nettype wire

### design/nat_rule_lookup_table.sv
// NAT rule table with wildcard lookup.
// Input stream (i_s_*): tuser selects insert (0) or lookup (1); tdata holds the
// rule key or flow key and, for an insert, the translated address and port.
// Output stream (o_m_*): one beat per input beat, in order; tuser is the status
// (stored, set full, exact hit, address-wildcard hit, port-wildcard hit, miss),
// tdata the translated address and port on a hit, zero otherwise.
// Rules live in two single-port-read memories with one row per hash set:
// a key row (WAYS keys) and a target row (WAYS targets), read together.
// An insert takes one row read and a write-back. A lookup takes one
// read-and-compare per probe, up to three probes in priority order (exact,
// address wildcard, port wildcard); each probe passes a read state and a
// compare state, as the row memory read is registered.
// The result beat is loaded into the output register after an insert's
// write-back, the first hit, or a miss on the third probe.
// After reset the key memory is swept clear, one set per cycle, over all
// 2**BUCKET_BITS sets; o_s_tready stays low meanwhile.
// A finished result sits in the output register; the next beat is accepted
// while it waits, and work stalls only when a second result is ready before
// the first has been taken.
`default_nettype none

module nat_rule_lookup_table #(
    parameter int BUCKET_BITS = nrlt_pkg::BUCKET_BITS_DEF,
    parameter int WAYS        = nrlt_pkg::WAYS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // key_ip[31:0], key_ip_any[32], key_port[48:33], key_port_any[49],
    // xlat_ip[81:50], xlat_port[97:82], zero fill [103:98]
    input  wire logic [nrlt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // op[0]
    input  wire logic                             i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // found_ip[31:0], found_port[47:32]
    output logic      [nrlt_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // status[2:0]
    output logic      [2:0]                       o_m_tuser
);

    localparam int NSETS  = 1 << BUCKET_BITS;
    localparam int NCHUNK = (nrlt_pkg::HASH_IN_W + BUCKET_BITS - 1) / BUCKET_BITS;
    localparam int KROW_W = WAYS * nrlt_pkg::KEY_W;
    localparam int TROW_W = WAYS * nrlt_pkg::TGT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        P_EXACT,
        P_IPANY,
        P_PORTANY
    } t_probe;

    // XOR-fold of the 16-bit hash input into a set index
    function automatic logic [BUCKET_BITS-1:0] fold_hash(
        input logic [nrlt_pkg::HASH_IN_W-1:0] v
    );
        logic [NCHUNK*BUCKET_BITS-1:0] ext;
        logic [BUCKET_BITS-1:0]        h;
        ext = '0;
        ext[nrlt_pkg::HASH_IN_W-1:0] = v;
        h = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            h = h ^ ext[i*BUCKET_BITS +: BUCKET_BITS];
        end
        return h;
    endfunction

    // row memories
    logic [KROW_W-1:0] r_key_mem [NSETS];
    logic [TROW_W-1:0] r_tgt_mem [NSETS];
    logic [KROW_W-1:0] r_key_rd;
    logic [TROW_W-1:0] r_tgt_rd;

    // control and item registers
    t_state                         r_state;
    t_probe                         r_probe;
    logic [BUCKET_BITS-1:0]         r_clr_addr;
    logic                           r_op;
    logic [nrlt_pkg::IP_W-1:0]      r_ip;
    logic                           r_ip_any;
    logic [nrlt_pkg::PORT_W-1:0]    r_port;
    logic                           r_port_any;
    logic [nrlt_pkg::IP_W-1:0]      r_xip;
    logic [nrlt_pkg::PORT_W-1:0]    r_xport;
    nrlt_pkg::t_status              r_res_status;
    logic [nrlt_pkg::TGT_W-1:0]     r_res_tgt;
    logic                           r_m_valid;
    nrlt_pkg::t_status              r_m_status;
    logic [nrlt_pkg::TGT_W-1:0]     r_m_tgt;

    // probe key and set
    logic                           cur_ip_any;
    logic                           cur_port_any;
    logic [nrlt_pkg::IP_W-1:0]      cur_ip;
    logic [nrlt_pkg::PORT_W-1:0]    cur_port;
    logic [nrlt_pkg::KEY_W-1:0]     cur_key;
    logic [BUCKET_BITS-1:0]         cur_set;

    // row compare and update
    logic [WAYS-1:0]                hit_sel;
    logic [WAYS-1:0]                free_sel;
    logic [WAYS-1:0]                wr_sel;
    logic                           any_hit;
    logic [KROW_W-1:0]              new_key_row;
    logic [TROW_W-1:0]              new_tgt_row;
    logic [nrlt_pkg::TGT_W-1:0]     hit_tgt;
    logic [nrlt_pkg::TGT_W-1:0]     ins_tgt;

    // memory write port
    logic                           key_we;
    logic                           tgt_we;
    logic [BUCKET_BITS-1:0]         wr_addr;
    logic [KROW_W-1:0]              key_wdata;

    logic                           s_beat;
    logic                           out_free;

    assign s_beat   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;

    // key for the current probe; wildcard parts count as zero
    always_comb begin
        if (r_op == nrlt_pkg::OP_INSERT) begin
            cur_ip_any   = r_ip_any;
            cur_port_any = r_port_any;
        end else begin
            cur_ip_any   = (r_probe == P_IPANY);
            cur_port_any = (r_probe == P_PORTANY);
        end
        cur_ip   = cur_ip_any   ? '0 : r_ip;
        cur_port = cur_port_any ? '0 : r_port;
        cur_key  = {1'b1, cur_ip_any, cur_ip, cur_port_any, cur_port};
        cur_set  = fold_hash({cur_ip[nrlt_pkg::OCTET_W-1:0], cur_port[nrlt_pkg::OCTET_W-1:0]});
    end

    nrlt_way_match #(
        .WAYS (WAYS)
    ) u_match (
        .i_row      (r_key_rd),
        .i_key      (cur_key),
        .o_hit_sel  (hit_sel),
        .o_free_sel (free_sel)
    );

    // way selection, merged rows and hit target
    always_comb begin
        any_hit     = |hit_sel;
        wr_sel      = any_hit ? hit_sel : free_sel;
        ins_tgt     = {r_xip, r_xport};
        new_key_row = r_key_rd;
        new_tgt_row = r_tgt_rd;
        hit_tgt     = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (wr_sel[w]) begin
                new_key_row[w*nrlt_pkg::KEY_W +: nrlt_pkg::KEY_W] = cur_key;
                new_tgt_row[w*nrlt_pkg::TGT_W +: nrlt_pkg::TGT_W] = ins_tgt;
            end
            if (hit_sel[w]) begin
                hit_tgt = hit_tgt | r_tgt_rd[w*nrlt_pkg::TGT_W +: nrlt_pkg::TGT_W];
            end
        end
    end

    // write control: clearing sweep or insert write-back
    always_comb begin
        tgt_we    = (r_state == S_CHECK) && (r_op == nrlt_pkg::OP_INSERT) && (|wr_sel);
        key_we    = (r_state == S_CLEAR) || tgt_we;
        wr_addr   = (r_state == S_CLEAR) ? r_clr_addr : cur_set;
        key_wdata = (r_state == S_CLEAR) ? '0 : new_key_row;
    end

    // key row memory
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[wr_addr] <= key_wdata;
        end
        r_key_rd <= r_key_mem[cur_set];
    end

    // target row memory
    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[wr_addr] <= new_tgt_row;
        end
        r_tgt_rd <= r_tgt_mem[cur_set];
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_op       <= i_s_tuser;
            r_ip       <= i_s_tdata[31:0];
            r_ip_any   <= i_s_tdata[32];
            r_port     <= i_s_tdata[48:33];
            r_port_any <= i_s_tdata[49];
            r_xip      <= i_s_tdata[81:50];
            r_xport    <= i_s_tdata[97:82];
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_probe    <= P_EXACT;
            r_m_valid  <= 1'b0;
        end else begin
            // output beat: load a finished result, else drop a taken one
            if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_beat) begin
                        r_probe <= P_EXACT;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_op == nrlt_pkg::OP_INSERT) begin
                        r_res_status <= (|wr_sel) ? nrlt_pkg::ST_STORED : nrlt_pkg::ST_FULL;
                        r_res_tgt    <= '0;
                        r_state      <= S_DONE;
                    end else if (any_hit) begin
                        unique case (r_probe)
                            P_EXACT:   r_res_status <= nrlt_pkg::ST_EXACT;
                            P_IPANY:   r_res_status <= nrlt_pkg::ST_IPANY;
                            default:   r_res_status <= nrlt_pkg::ST_PORTANY;
                        endcase
                        r_res_tgt <= hit_tgt;
                        r_state   <= S_DONE;
                    end else if (r_probe == P_PORTANY) begin
                        r_res_status <= nrlt_pkg::ST_MISS;
                        r_res_tgt    <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_probe <= (r_probe == P_EXACT) ? P_IPANY : P_PORTANY;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_m_status <= r_res_status;
                        r_m_tgt    <= r_res_tgt;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {r_m_tgt[nrlt_pkg::PORT_W-1:0],
                         r_m_tgt[nrlt_pkg::TGT_W-1:nrlt_pkg::PORT_W]};

endmodule

`default_nettype wire

### design/nrlt_way_match.sv
`default_nettype none

// Compares one set row against a search key: one-hot hit and lowest free way.
module nrlt_way_match #(
    parameter int WAYS = nrlt_pkg::WAYS_DEF
) (
    input  wire logic [WAYS*nrlt_pkg::KEY_W-1:0] i_row,
    input  wire logic [nrlt_pkg::KEY_W-1:0]      i_key,
    output logic      [WAYS-1:0]                 o_hit_sel,
    output logic      [WAYS-1:0]                 o_free_sel
);

    logic [WAYS-1:0] free_vec;

    // per-way key compare and empty flag
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            o_hit_sel[w] = (i_row[w*nrlt_pkg::KEY_W +: nrlt_pkg::KEY_W] == i_key);
            free_vec[w]  = !i_row[w*nrlt_pkg::KEY_W + nrlt_pkg::KEY_VALID_B];
        end
    end

    // lowest free way, one-hot
    always_comb begin
        logic taken;
        taken      = 1'b0;
        o_free_sel = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (free_vec[w] && !taken) begin
                o_free_sel[w] = 1'b1;
                taken         = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
